### rtl/dtc_pkg.sv
// ----------------------------------------------------------------------------
// Divider/timer counter package
// Shared widths, operation codes, control/status bundles and helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package dtc_pkg;

  localparam int OpW      = 3;
  localparam int ByteW    = 8;
  localparam int SysW     = 16;
  localparam int CtlW     = 3;
  localparam int ShiftW   = 4;
  localparam int LowW     = 11;  // low system counter bits below the widest period
  localparam int StepsW   = 5;   // at most sixteen increments per tick transfer
  localparam int DistW    = 19;
  localparam int InDataW  = 24;
  localparam int OutDataW = 40;

  localparam logic [ByteW-1:0] TopCount = 8'hFF;

  typedef enum logic [OpW-1:0] {
    OP_TICK    = 3'd0,
    OP_DIVIDER = 3'd1,
    OP_CONTROL = 3'd2,
    OP_COUNTER = 3'd3,
    OP_MODULO  = 3'd4
  } op_t;

  typedef struct packed {
    logic load_in;
    logic exec;
    logic bump;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic steps_zero;
    logic out_free;
  } status_t;

  // Period exponent selected by the low two control bits.
  function automatic logic [ShiftW-1:0] period_shift(input logic [1:0] sel);
    logic [ShiftW-1:0] s;
    case (sel)
      2'd0:    s = 4'd10;
      2'd1:    s = 4'd4;
      2'd2:    s = 4'd6;
      default: s = 4'd8;
    endcase
    return s;
  endfunction

  // Level of the selected divider bit, forced low while the timer is disabled.
  function automatic logic tap_level(input logic [CtlW-1:0] ctl,
                                     input logic [SysW-1:0] sc);
    logic [ShiftW-1:0] sh;
    sh = period_shift(ctl[1:0]);
    return ctl[2] & sc[sh - 4'd1];
  endfunction

endpackage

`default_nettype wire

### rtl/dtc_ctrl.sv
// ----------------------------------------------------------------------------
// Divider/timer counter controller
// Sequences capture, register update, timer increments and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module dtc_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire dtc_pkg::status_t status,
  output dtc_pkg::cmd_t       cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_BUMP = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = ST_BUMP;
      end
      ST_BUMP: begin
        // One timer increment per cycle until the pending count drains.
        if (status.steps_zero) begin
          state_next = ST_DONE;
        end else begin
          cmd.bump = 1'b1;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/dtc_datapath.sv
// ----------------------------------------------------------------------------
// Divider/timer counter datapath
// Holds the timer registers, the pending increment count and the result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module dtc_datapath (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire dtc_pkg::cmd_t                   cmd,
  output dtc_pkg::status_t                     status,
  input  wire logic [dtc_pkg::InDataW-1:0]     in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [dtc_pkg::OutDataW-1:0]         out_data,
  output logic                                 out_irq
);

  logic [dtc_pkg::OpW-1:0]    op_q;
  logic [dtc_pkg::ByteW-1:0]  cycles_q;
  logic [dtc_pkg::ByteW-1:0]  value_q;

  logic [dtc_pkg::SysW-1:0]   sys_cnt;
  logic [dtc_pkg::ByteW-1:0]  tim_cnt;
  logic [dtc_pkg::ByteW-1:0]  mod_val;
  logic [dtc_pkg::CtlW-1:0]   ctl;
  logic [dtc_pkg::StepsW-1:0] steps;
  logic                       irq;

  logic [dtc_pkg::ShiftW-1:0] shift;
  logic [dtc_pkg::LowW-1:0]   period;
  logic [dtc_pkg::LowW-1:0]   low;
  logic [dtc_pkg::LowW:0]     low_sum;
  logic [dtc_pkg::CtlW-1:0]   ctl_new;
  logic [dtc_pkg::LowW-1:0]   until_edge;
  logic [dtc_pkg::DistW-1:0]  ovf_dist;

  always_comb begin
    shift      = dtc_pkg::period_shift(ctl[1:0]);
    period     = dtc_pkg::LowW'(1) << shift;
    low        = sys_cnt[dtc_pkg::LowW-1:0] & (period - dtc_pkg::LowW'(1));
    // Crossings of a period boundary while adding the tick count.
    low_sum    = {1'b0, low} + (dtc_pkg::LowW+1)'(cycles_q);
    ctl_new    = value_q[dtc_pkg::CtlW-1:0];
    until_edge = period - low;
    if (ctl[2]) begin
      ovf_dist = (dtc_pkg::DistW'(dtc_pkg::TopCount - tim_cnt) << shift)
                 + dtc_pkg::DistW'(until_edge);
    end else begin
      ovf_dist = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_q     <= in_data[2:0];
      cycles_q <= in_data[10:3];
      value_q  <= in_data[18:11];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sys_cnt <= '0;
      tim_cnt <= '0;
      mod_val <= '0;
      ctl     <= '0;
      steps   <= '0;
      irq     <= 1'b0;
    end else if (cmd.load_in) begin
      irq   <= 1'b0;
      steps <= '0;
    end else if (cmd.exec) begin
      case (op_q)
        dtc_pkg::OP_TICK: begin
          sys_cnt <= sys_cnt + dtc_pkg::SysW'(cycles_q);
          if (ctl[2]) begin
            steps <= dtc_pkg::StepsW'(low_sum >> shift);
          end
        end
        dtc_pkg::OP_DIVIDER: begin
          sys_cnt <= '0;
          steps   <= dtc_pkg::StepsW'(dtc_pkg::tap_level(ctl, sys_cnt));
        end
        dtc_pkg::OP_CONTROL: begin
          ctl   <= ctl_new;
          steps <= dtc_pkg::StepsW'(dtc_pkg::tap_level(ctl, sys_cnt)
                                    & ~dtc_pkg::tap_level(ctl_new, sys_cnt));
        end
        dtc_pkg::OP_COUNTER: begin
          tim_cnt <= value_q;
        end
        dtc_pkg::OP_MODULO: begin
          mod_val <= value_q;
        end
        default: begin
        end
      endcase
    end else if (cmd.bump) begin
      steps <= steps - dtc_pkg::StepsW'(1);
      if (tim_cnt == dtc_pkg::TopCount) begin
        tim_cnt <= mod_val;
        irq     <= 1'b1;
      end else begin
        tim_cnt <= tim_cnt + dtc_pkg::ByteW'(1);
      end
    end
  end

  // Result stage: frees the core to take the next transfer while this one waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data <= {5'd0, ovf_dist, sys_cnt[15:8], tim_cnt};
      out_irq  <= irq;
    end
  end

  assign status.steps_zero = (steps == '0);
  assign status.out_free   = ~out_valid | out_ready;

  a_bump_needs_steps: assert property (@(posedge clk) disable iff (rst)
    cmd.bump |-> steps != '0)
    else $error("timer increment issued with no pending steps");

  a_steps_bound: assert property (@(posedge clk) disable iff (rst)
    steps <= dtc_pkg::StepsW'(16))
    else $error("pending increment count exceeds sixteen");

  a_load_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> status.out_free)
    else $error("result stage overwritten while still holding a transfer");

  a_write_no_steps: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && (op_q == dtc_pkg::OP_COUNTER || op_q == dtc_pkg::OP_MODULO)
    |=> steps == '0)
    else $error("register write produced timer increments");

endmodule

`default_nettype wire

### rtl/divider_timer_counter.sv
// ----------------------------------------------------------------------------
// Divider/timer counter
// Console system counter with a programmable timer, modulo reload and IRQ.
// ----------------------------------------------------------------------------
// Usage: each transfer on the s_ side carries one operation (tick, divider
// write, control write, counter write or modulo write). Exactly one result
// transfer leaves on the m_ side per input, in order, carrying the timer
// counter, the divider byte, the cycles left to the next overflow and, in
// m_tuser, an interrupt pulse flag.
// Sequence: an item is captured on acceptance, executed, then given n timer
// increments (0 to 16 for a tick, at most 1 for a divider or control write)
// before it is loaded into the result stage. The increments run one per
// cycle through the timer counter's incrementer, which sets the rate.
// A new item is accepted in the cycle after the previous one is handed to
// the result register; no new item is taken while one is still in work.
// Reset clears all timer registers and empties the result register.
// When the receiver stalls, the result stays in the output register; the
// block finishes the next item and then waits until the register is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module divider_timer_counter (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // op [2:0], cycles [10:3], value [18:11], zero fill above
  input  wire logic [dtc_pkg::InDataW-1:0]     s_tdata,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // timer_count [7:0], divider_byte [15:8], cycles_to_overflow [34:16]
  output logic [dtc_pkg::OutDataW-1:0]         m_tdata,
  // timer_irq [0]
  output logic [0:0]                           m_tuser
);

  dtc_pkg::cmd_t    cmd;
  dtc_pkg::status_t status;

  dtc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  dtc_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (s_tdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_irq   (m_tuser[0])
  );

endmodule

`default_nettype wire

### tb/divider_timer_counter_test.sv
// ----------------------------------------------------------------------------
// Divider/timer counter testbench
// Drives tick, divider, control, counter, modulo and spare operations into
// the block and checks every result transfer against a cycle-free predictor
// of the system counter, timer counter, modulo reload and interrupt pulse.
// Both stream sides idle in random bursts; one phase holds the result side
// off long enough to back the block up, and the last phase runs at full rate.
// ----------------------------------------------------------------------------
module divider_timer_counter_test;

  localparam logic [dtc_pkg::OpW-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [dtc_pkg::OpW-1:0] OP_SPARE_LAST  = 3'd7;
  localparam int CTL_ENABLE   = 2;
  localparam int STALL_CYCLES = 200;
  localparam int WATCH_LIMIT  = 1500;
  localparam int TAIL_CYCLES  = 32;

  typedef struct packed {
    logic [7:0]  timer_count;
    logic [7:0]  divider_byte;
    logic        timer_irq;
    logic [18:0] overflow_dist;
  } timer_result_t;

  logic                         clk;
  logic                         rst;
  logic                         s_tvalid;
  logic                         s_tready;
  logic [dtc_pkg::InDataW-1:0]  s_tdata;
  logic                         m_tvalid;
  logic                         m_tready;
  logic [dtc_pkg::OutDataW-1:0] m_tdata;
  logic [0:0]                   m_tuser;

  divider_timer_counter i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Predicted timer state.
  logic [15:0] pred_sys;
  logic [7:0]  pred_timer;
  logic [7:0]  pred_modulo;
  logic [2:0]  pred_control;
  logic        pred_irq;

  timer_result_t pending_results[$];
  int          err_count;
  bit          idle_on;
  bit          hold_req;
  int          quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int timer_shift(input logic [1:0] sel);
    case (sel)
      2'd0:    return 10;
      2'd1:    return 4;
      2'd2:    return 6;
      default: return 8;
    endcase
  endfunction

  function automatic logic tap_high(input logic [2:0] ctl, input logic [15:0] sc);
    return ctl[CTL_ENABLE] && sc[timer_shift(ctl[1:0]) - 1];
  endfunction

  function automatic void bump_timer();
    if (pred_timer == 8'hFF) begin
      pred_timer = pred_modulo;
      pred_irq   = 1'b1;
    end else begin
      pred_timer = pred_timer + 8'd1;
    end
  endfunction

  function automatic timer_result_t predict_timer_result(
      input logic [dtc_pkg::OpW-1:0] op,
      input logic [7:0] cyc,
      input logic [7:0] val);
    timer_result_t r;
    logic [15:0]   prior;
    logic [2:0]    nxt;
    int            sh;
    int            steps;
    int            period;
    int            ovf_dist;
    pred_irq = 1'b0;
    case (op)
      dtc_pkg::OP_TICK: begin
        prior    = pred_sys;
        pred_sys = pred_sys + {8'd0, cyc};
        if (pred_control[CTL_ENABLE]) begin
          sh    = timer_shift(pred_control[1:0]);
          // Crossings are counted modulo the span so a wrap counts like any other.
          steps = ((int'(pred_sys) >> sh) - (int'(prior) >> sh)) & ((1 << (16 - sh)) - 1);
          for (int i = 0; i < steps; i++) bump_timer();
        end
      end
      dtc_pkg::OP_DIVIDER: begin
        if (tap_high(pred_control, pred_sys)) bump_timer();
        pred_sys = 16'd0;
      end
      dtc_pkg::OP_CONTROL: begin
        nxt = val[2:0];
        if (tap_high(pred_control, pred_sys) && !tap_high(nxt, pred_sys)) bump_timer();
        pred_control = nxt;
      end
      dtc_pkg::OP_COUNTER: pred_timer  = val;
      dtc_pkg::OP_MODULO:  pred_modulo = val;
      default: ;
    endcase
    ovf_dist = 0;
    if (pred_control[CTL_ENABLE]) begin
      period   = 1 << timer_shift(pred_control[1:0]);
      ovf_dist = (period - (int'(pred_sys) & (period - 1)))
                 + (255 - int'(pred_timer)) * period;
    end
    r.timer_count   = pred_timer;
    r.divider_byte  = pred_sys[15:8];
    r.timer_irq     = pred_irq;
    r.overflow_dist = ovf_dist[18:0];
    return r;
  endfunction

  // Result checking and prediction share one process so that a result is
  // always compared before a transfer in the same cycle adds an entry.
  always @(posedge clk) begin
    timer_result_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with no prediction waiting");
          err_count++;
        end else begin
          want = pending_results.pop_front();
          if (m_tdata[7:0] !== want.timer_count) begin
            $error("timer_count mismatch: expected %0d, actual %0d",
                   want.timer_count, m_tdata[7:0]);
            err_count++;
          end
          if (m_tdata[15:8] !== want.divider_byte) begin
            $error("divider_byte mismatch: expected %0d, actual %0d",
                   want.divider_byte, m_tdata[15:8]);
            err_count++;
          end
          if (m_tdata[34:16] !== want.overflow_dist) begin
            $error("cycles_to_overflow mismatch: expected %0d, actual %0d",
                   want.overflow_dist, m_tdata[34:16]);
            err_count++;
          end
          if (m_tuser[0] !== want.timer_irq) begin
            $error("timer_irq mismatch: expected %0d, actual %0d",
                   want.timer_irq, m_tuser[0]);
            err_count++;
          end
        end
      end
      if (s_tvalid && s_tready)
        pending_results.push_back(predict_timer_result(s_tdata[2:0], s_tdata[10:3],
                                                       s_tdata[18:11]));
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCH_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: random hold-off bursts, or one long hold on request.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (STALL_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(0, 7)) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(input logic [dtc_pkg::OpW-1:0] op, input logic [7:0] cyc,
                           input logic [7:0] val);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'd0, val, cyc, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [dtc_pkg::OpW-1:0] pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return dtc_pkg::OP_TICK;
    if (r < 63) return dtc_pkg::OP_DIVIDER;
    if (r < 75) return dtc_pkg::OP_CONTROL;
    if (r < 85) return dtc_pkg::OP_COUNTER;
    if (r < 95) return dtc_pkg::OP_MODULO;
    return OP_SPARE_FIRST + 3'($urandom_range(0, OP_SPARE_LAST - OP_SPARE_FIRST));
  endfunction

  function automatic logic [7:0] pick_cycles();
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Control bytes mostly enable the timer; counter bytes lean toward the top.
  function automatic logic [7:0] pick_value(input logic [dtc_pkg::OpW-1:0] op);
    logic [7:0] v;
    v = 8'($urandom_range(0, 255));
    if (op == dtc_pkg::OP_CONTROL && $urandom_range(0, 9) < 8) v[CTL_ENABLE] = 1'b1;
    if (op == dtc_pkg::OP_COUNTER && $urandom_range(0, 2) == 0)
      v = 8'hFF - 8'($urandom_range(0, 3));
    return v;
  endfunction

  task automatic send_random(input int count);
    logic [dtc_pkg::OpW-1:0] op;
    repeat (count) begin
      op = pick_op();
      send_item(op, pick_cycles(), pick_value(op));
    end
  endtask

  task automatic test_directed_edges();
    send_item(dtc_pkg::OP_TICK, 8'd0, 8'hFF);
    send_item(dtc_pkg::OP_TICK, 8'hFF, 8'h00);     // disabled timer still moves the divider
    send_item(dtc_pkg::OP_MODULO, 8'hFF, 8'hFF);
    send_item(dtc_pkg::OP_CONTROL, 8'h00, 8'hFD);  // only the low three bits are kept
    send_item(dtc_pkg::OP_COUNTER, 8'h00, 8'hFF);
    send_item(dtc_pkg::OP_TICK, 8'd16, 8'h00);     // overflow reloads from the modulo
    send_item(dtc_pkg::OP_TICK, 8'hFF, 8'hFF);
    send_item(OP_SPARE_FIRST, 8'hFF, 8'hFF);
    send_item(OP_SPARE_FIRST + 3'd1, 8'h55, 8'hAA);
    send_item(OP_SPARE_LAST, 8'h00, 8'h00);
    send_item(dtc_pkg::OP_DIVIDER, 8'hFF, 8'hFF);
    send_item(dtc_pkg::OP_TICK, 8'd8, 8'h00);
    send_item(dtc_pkg::OP_DIVIDER, 8'h00, 8'h00);  // selected bit high, so the write counts
    send_item(dtc_pkg::OP_TICK, 8'd8, 8'h00);
    send_item(dtc_pkg::OP_CONTROL, 8'h00, 8'h00);  // disabling on a high bit counts once
    send_item(dtc_pkg::OP_MODULO, 8'h00, 8'h00);
    send_item(dtc_pkg::OP_COUNTER, 8'h00, 8'h00);
    send_item(dtc_pkg::OP_CONTROL, 8'h00, 8'h04);
    repeat (4) send_item(dtc_pkg::OP_TICK, 8'hFF, 8'h00);
    send_item(dtc_pkg::OP_CONTROL, 8'h00, 8'h07);
    send_item(dtc_pkg::OP_COUNTER, 8'h00, 8'hFF);
    send_item(dtc_pkg::OP_TICK, 8'hFF, 8'h00);
    send_item(dtc_pkg::OP_CONTROL, 8'h00, 8'h06);  // period change with both taps low
  endtask

  // Runs forty ticks of the system counter under each period select.
  task automatic test_period_select();
    for (int sel = 0; sel < 4; sel++) begin
      send_item(dtc_pkg::OP_CONTROL, 8'h00, 8'(4 + sel));
      send_item(dtc_pkg::OP_MODULO, 8'h00, 8'($urandom_range(0, 255)));
      send_item(dtc_pkg::OP_COUNTER, 8'h00, 8'($urandom_range(0, 255)));
      repeat (40) send_item(dtc_pkg::OP_TICK, pick_cycles(), 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_random_mix();
    send_random(1300);
  endtask

  task automatic test_output_stall();
    hold_req = 1'b1;
    send_item(dtc_pkg::OP_CONTROL, 8'h00, 8'h05);
    send_random(30);
  endtask

  task automatic test_full_rate();
    idle_on = 1'b0;
    send_random(200);
  endtask

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    err_count = 0;
    idle_on   = 1'b1;
    hold_req  = 1'b0;
    pred_sys     = 16'd0;
    pred_timer   = 8'd0;
    pred_modulo  = 8'd0;
    pred_control = 3'd0;
    pred_irq     = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed_edges();
    test_period_select();
    test_random_mix();
    test_output_stall();
    test_full_rate();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
